// ----- hdl/two_queue_starvation_free_scheduler_top_assert.svh -----
// Assertion helpers shared by the scheduler RTL.
`ifndef TWO_QUEUE_STARVATION_FREE_SCHEDULER_TOP_ASSERT_SVH
`define TWO_QUEUE_STARVATION_FREE_SCHEDULER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TQS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tqs_pkg.sv -----
package tqs_pkg;

    localparam int ID_W         = 4;
    localparam int COUNT_W      = 6;
    localparam int PERIOD_W     = 8;
    localparam int TASKS_DEF    = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd10;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef struct packed {
        logic            command;
        logic [ID_W-1:0] task_id;
        logic            task_finished;
        logic            task_waiting;
    } t_in_item;

    typedef struct packed {
        logic               pop_valid;
        logic [ID_W-1:0]    pop_task_id;
        logic               from_waiting;
        logic               push_overflow;
        logic               all_idle;
        logic [COUNT_W-1:0] task_count;
    } t_out_item;

endpackage

// ----- hdl/tqs_ram.sv -----
module tqs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/two_queue_starvation_free_scheduler_top.sv -----
// Three-stage pipeline: input register, queue update with FIFO RAM read, result register.
// An accepted transaction moves from the input register to stage 2 and then to the result register.
// Throughput is one transaction per cycle; a stalled result holds the whole pipeline.
// Reset (synchronous, active low) empties both queues, clears all handed-out marks,
// zeroes the phase counter and loads the waiting period with its default of 10.
`include "two_queue_starvation_free_scheduler_top_assert.svh"

module two_queue_starvation_free_scheduler_top #(
    parameter int TASKS = tqs_pkg::TASKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tqs_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tqs_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_wr_en,
    input  logic [tqs_pkg::PERIOD_W-1:0]    i_cfg_wr_data
);

    localparam int AW   = $clog2(TASKS);
    localparam int FW   = $clog2(TASKS + 1);
    localparam int SW   = $clog2(2 * TASKS + 1);
    localparam int TW   = $clog2(3 * TASKS + 1);
    localparam int IDW  = tqs_pkg::ID_W;
    localparam int PW   = tqs_pkg::PERIOD_W;

    // Pipeline enable: everything moves unless the result is held by the consumer.
    logic en;

    // Stage 1: input register.
    logic              r_s1_vld;
    tqs_pkg::t_in_item r_s1;

    // Queue state.
    logic [AW-1:0] r_ready_head,   n_ready_head;
    logic [FW-1:0] r_ready_fill,   n_ready_fill;
    logic [AW-1:0] r_waiting_head, n_waiting_head;
    logic [FW-1:0] r_waiting_fill, n_waiting_fill;
    logic [PW-1:0] r_phase,        n_phase;
    logic [PW-1:0] r_period;

    // Stage 2: decision made, FIFO read data arriving from the RAM.
    logic           r_s2_vld;
    logic           r_s2_pop,    n_s2_pop;
    logic           r_s2_from_w, n_s2_from_w;
    logic           r_s2_ovf,    n_s2_ovf;
    logic           r_s2_clr,    n_s2_clr;
    logic [IDW-1:0] r_s2_id;
    logic [SW-1:0]  r_s2_fill_sum;

    // Handed-out marks and their running count.
    logic [TASKS-1:0] r_marks,    n_marks;
    logic [FW-1:0]    r_mark_cnt, n_mark_cnt;

    // Stage 3: result register.
    logic               r_s3_vld;
    tqs_pkg::t_out_item r_s3, n_s3;

    // RAM ports.
    logic           ready_we, ready_re, waiting_we, waiting_re;
    logic [AW-1:0]  ready_waddr, waiting_waddr;
    logic [IDW-1:0] ready_rdata, waiting_rdata;
    logic [AW:0]    ready_tail_sum, waiting_tail_sum;
    logic [PW:0]    phase_inc;
    logic           id_ok;
    logic [IDW-1:0] got;
    logic [TW-1:0]  total;

    assign en          = !(r_s3_vld && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_s3_vld;
    assign o_out_item  = r_s3;

    // Tail address is head plus fill, wrapped once at the queue depth.
    assign ready_tail_sum   = (AW+1)'(r_ready_head) + (AW+1)'(r_ready_fill);
    assign waiting_tail_sum = (AW+1)'(r_waiting_head) + (AW+1)'(r_waiting_fill);
    assign ready_waddr      = (ready_tail_sum >= (AW+1)'(TASKS))
                            ? AW'(ready_tail_sum - (AW+1)'(TASKS)) : AW'(ready_tail_sum);
    assign waiting_waddr    = (waiting_tail_sum >= (AW+1)'(TASKS))
                            ? AW'(waiting_tail_sum - (AW+1)'(TASKS)) : AW'(waiting_tail_sum);

    assign phase_inc = {1'b0, r_phase} + (PW+1)'(1);
    assign id_ok     = int'(r_s1.task_id) < TASKS;

    always_comb begin
        n_ready_head   = r_ready_head;
        n_ready_fill   = r_ready_fill;
        n_waiting_head = r_waiting_head;
        n_waiting_fill = r_waiting_fill;
        n_phase        = r_phase;
        n_s2_pop       = 1'b0;
        n_s2_from_w    = 1'b0;
        n_s2_ovf       = 1'b0;
        n_s2_clr       = 1'b0;
        ready_we       = 1'b0;
        ready_re       = 1'b0;
        waiting_we     = 1'b0;
        waiting_re     = 1'b0;
        if (r_s1_vld) begin
            if (r_s1.command == tqs_pkg::CMD_PUSH) begin
                if (id_ok) begin
                    n_s2_clr = 1'b1;
                    if (!r_s1.task_finished) begin
                        if (r_s1.task_waiting) begin
                            if (r_waiting_fill == FW'(TASKS)) begin
                                n_s2_ovf = 1'b1;
                            end else begin
                                waiting_we     = en;
                                n_waiting_fill = r_waiting_fill + FW'(1);
                            end
                        end else begin
                            if (r_ready_fill == FW'(TASKS)) begin
                                n_s2_ovf = 1'b1;
                            end else begin
                                ready_we     = en;
                                n_ready_fill = r_ready_fill + FW'(1);
                            end
                        end
                    end
                end
            end else if (r_ready_fill != '0 || r_waiting_fill != '0) begin
                n_s2_pop = 1'b1;
                // A period of zero wraps exactly like a period of one.
                n_phase  = (phase_inc >= {1'b0, r_period}) ? '0 : PW'(phase_inc);
                if ((n_phase == '0 && r_waiting_fill != '0) || r_ready_fill == '0) begin
                    n_s2_from_w    = 1'b1;
                    waiting_re     = en;
                    n_waiting_fill = r_waiting_fill - FW'(1);
                    n_waiting_head = (r_waiting_head == AW'(TASKS - 1))
                                   ? '0 : r_waiting_head + AW'(1);
                end else begin
                    ready_re     = en;
                    n_ready_fill = r_ready_fill - FW'(1);
                    n_ready_head = (r_ready_head == AW'(TASKS - 1))
                                 ? '0 : r_ready_head + AW'(1);
                end
            end
        end
    end

    tqs_ram #(
        .WIDTH (IDW),
        .DEPTH (TASKS)
    ) u_ready_ram (
        .i_clk   (i_clk),
        .i_we    (ready_we),
        .i_waddr (ready_waddr),
        .i_wdata (r_s1.task_id),
        .i_re    (ready_re),
        .i_raddr (r_ready_head),
        .o_rdata (ready_rdata)
    );

    tqs_ram #(
        .WIDTH (IDW),
        .DEPTH (TASKS)
    ) u_waiting_ram (
        .i_clk   (i_clk),
        .i_we    (waiting_we),
        .i_waddr (waiting_waddr),
        .i_wdata (r_s1.task_id),
        .i_re    (waiting_re),
        .i_raddr (r_waiting_head),
        .o_rdata (waiting_rdata)
    );

    // Marks are updated in stage 2, in transaction order, once the popped id is known.
    assign got = r_s2_from_w ? waiting_rdata : ready_rdata;

    always_comb begin
        n_marks    = r_marks;
        n_mark_cnt = r_mark_cnt;
        if (r_s2_vld) begin
            if (r_s2_clr && r_marks[AW'(r_s2_id)]) begin
                n_marks[AW'(r_s2_id)] = 1'b0;
                n_mark_cnt            = r_mark_cnt - FW'(1);
            end
            if (r_s2_pop && int'(got) < TASKS && !r_marks[AW'(got)]) begin
                n_marks[AW'(got)] = 1'b1;
                n_mark_cnt        = r_mark_cnt + FW'(1);
            end
        end
    end

    assign total = TW'(r_s2_fill_sum) + TW'(n_mark_cnt);

    always_comb begin
        n_s3.pop_valid     = r_s2_pop;
        n_s3.pop_task_id   = r_s2_pop ? got : '0;
        n_s3.from_waiting  = r_s2_pop && r_s2_from_w;
        n_s3.push_overflow = r_s2_ovf;
        n_s3.all_idle      = (total == '0);
        n_s3.task_count    = tqs_pkg::COUNT_W'(total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld       <= 1'b0;
            r_s2_vld       <= 1'b0;
            r_s3_vld       <= 1'b0;
            r_ready_head   <= '0;
            r_ready_fill   <= '0;
            r_waiting_head <= '0;
            r_waiting_fill <= '0;
            r_phase        <= '0;
            r_period       <= tqs_pkg::PERIOD_RESET;
            r_marks        <= '0;
            r_mark_cnt     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
            if (en) begin
                r_s1_vld       <= i_in_valid;
                r_s2_vld       <= r_s1_vld;
                r_s3_vld       <= r_s2_vld;
                r_ready_head   <= n_ready_head;
                r_ready_fill   <= n_ready_fill;
                r_waiting_head <= n_waiting_head;
                r_waiting_fill <= n_waiting_fill;
                r_phase        <= n_phase;
                r_marks        <= n_marks;
                r_mark_cnt     <= n_mark_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1          <= i_in_item;
            r_s2_pop      <= n_s2_pop;
            r_s2_from_w   <= n_s2_from_w;
            r_s2_ovf      <= n_s2_ovf;
            r_s2_clr      <= n_s2_clr;
            r_s2_id       <= r_s1.task_id;
            r_s2_fill_sum <= SW'(n_ready_fill) + SW'(n_waiting_fill);
            r_s3          <= n_s3;
        end
    end

    `TQS_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, (int'(r_ready_fill) <= TASKS && int'(r_waiting_fill) <= TASKS), "queue fill exceeds depth")
    `TQS_ASSERT_SAME(a_mark_count, i_clk, i_rst_n, 1'b1, (int'(r_mark_cnt) == $countones(r_marks)), "mark count out of step with marks")
    `TQS_ASSERT_NEXT(a_pop_served, i_clk, i_rst_n, (en && r_s1_vld && r_s1.command == tqs_pkg::CMD_POP && (r_ready_fill != '0 || r_waiting_fill != '0)), (r_s2_vld && r_s2_pop), "pop on a non-empty queue served nothing")

endmodule
